// ===== rtl/core/b64_pkg.sv =====
// Shared types, constants and the character map of the base64 decoder.
package b64_pkg;

	// Counter width for character, pad and byte counts
	localparam int COUNT_WIDTH = 32;
	// Decoded bytes held back until the end of the string is known
	localparam int HOLD_DEPTH = 2;
	// Results one character can cause at most
	localparam int MAX_RES = HOLD_DEPTH + 1;
	// Entries of the result queue
	localparam int QDEPTH = 4;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;

	localparam cnt_t BYTES_PER_GROUP = cnt_t'(3);

	// Special characters
	localparam logic [7:0] CH_PAD   = 8'h3D; // '='
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	localparam logic [5:0] DIG_PLUS  = 6'd62;
	localparam logic [5:0] DIG_SLASH = 6'd63;

	// Bit offset after reset: no bits in the accumulator yet
	localparam logic signed [3:0] OFF_RESET = -4'sd8;
	localparam logic signed [3:0] OFF_STEP  = 4'sd6;
	localparam logic signed [3:0] OFF_BYTE  = 4'sd8;

	// One result beat
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       decode_error;
		logic       last_result;
	} res_t;

	// Results of one character, handed to the output queue
	typedef struct packed {
		logic [1:0]         num;
		res_t [MAX_RES-1:0] item;
	} batch_t;

	// Alphabet map: {valid, 6-bit digit}
	function automatic logic [6:0] b64_map(input logic [7:0] c);
		logic [6:0] r;
		r = '0;
		if (c inside {[8'h41:8'h5A]}) begin
			r = {1'b1, 6'(c - 8'h41)};
		end else if (c inside {[8'h61:8'h7A]}) begin
			r = {1'b1, 6'(c - 8'h47)};
		end else if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, 6'(c + 8'h04)};
		end else if (c == CH_PLUS) begin
			r = {1'b1, DIG_PLUS};
		end else if (c == CH_SLASH) begin
			r = {1'b1, DIG_SLASH};
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/b64_char_if.sv =====
// Input channel: one encoded character per beat.
interface b64_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       end_of_string;

	modport source(output valid, char_in, end_of_string, input ready);
	modport sink(input valid, char_in, end_of_string, output ready);
endinterface

// ===== rtl/core/b64_res_if.sv =====
// Output channel: one decoded result per beat.
interface b64_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       decode_error;
	logic       last_result;

	modport source(output valid, out_byte, byte_valid, decode_error, last_result,
		input ready);
	modport sink(input valid, out_byte, byte_valid, decode_error, last_result,
		output ready);
endinterface

// ===== rtl/core/b64_decode.sv =====
// Input register, decode state and per-character result generation.
module b64_decode import b64_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	b64_char_if.sink        char_ch,
	input  logic            room,
	output batch_t          batch
);

	// Input stage
	logic       v_s1;
	logic [7:0] char_s1;
	logic       eos_s1;
	logic       adv;

	// Decode state
	logic [11:0]       acc_q;
	logic signed [3:0] off_q;
	logic [7:0]        held_q [HOLD_DEPTH];
	logic [1:0]        hcnt_q;
	cnt_t              bytes_q;
	cnt_t              chars_q;
	cnt_t              groups_q;
	cnt_t              pad_q;
	logic              err_q;

	// Next-state and result logic
	logic              active, is_pad, is_ws, dig, has_new, err_n, no_cut;
	logic [6:0]        mc;
	logic [11:0]       acc_sh, acc_n;
	logic signed [3:0] off_add, off_n;
	logic [7:0]        nb;
	cnt_t              chars_n, pad_n, bytes_n, groups_n, expected, idx;
	logic [1:0]        np, n;
	logic [7:0]        pend [MAX_RES];
	logic [MAX_RES-1:0] keep;

	assign adv = v_s1 && room;
	assign char_ch.ready = !v_s1 || room;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (char_ch.ready) begin
			v_s1 <= char_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ch.ready && char_ch.valid) begin
			char_s1 <= char_ch.char_in;
			eos_s1  <= char_ch.end_of_string;
		end
	end

	// Character classification and accumulator step
	always_comb begin
		active  = !err_q;
		mc      = b64_map(char_s1);
		is_pad  = (char_s1 == CH_PAD);
		is_ws   = (char_s1 == CH_LF) || (char_s1 == CH_CR) || (char_s1 == CH_SPACE);
		chars_n = active ? chars_q + cnt_t'(1) : chars_q;
		pad_n   = (active && is_pad) ? pad_q + cnt_t'(1) : pad_q;
		err_n   = err_q || (active && !is_pad && ((pad_q != '0) || (!is_ws && !mc[6])));
		dig     = active && !is_pad && (pad_q == '0) && !is_ws && mc[6];
		acc_sh  = {acc_q[5:0], mc[5:0]};
		off_add = off_q + OFF_STEP;
		has_new = dig && !off_add[3];
		nb      = 8'(acc_sh >> off_add[2:0]);
		acc_n   = dig ? acc_sh : acc_q;
		off_n   = !dig ? off_q : (has_new ? off_add - OFF_BYTE : off_add);
		bytes_n = has_new ? bytes_q + cnt_t'(1) : bytes_q;
		// floor(chars/4)*3 kept running; back to zero when the count wraps
		if (chars_n == '0) begin
			groups_n = '0;
		end else if (active && (chars_n[1:0] == 2'b00)) begin
			groups_n = groups_q + BYTES_PER_GROUP;
		end else begin
			groups_n = groups_q;
		end
	end

	// Results of the current character
	always_comb begin
		batch    = '0;
		np       = hcnt_q + 2'(has_new);
		no_cut   = pad_n > groups_n;
		expected = groups_n - pad_n;
		pend[0]  = (hcnt_q >= 2'd1) ? held_q[0] : nb;
		pend[1]  = (hcnt_q >= 2'd2) ? held_q[1] : nb;
		pend[2]  = nb;
		keep     = '0;
		idx      = '0;
		n        = '0;
		for (int i = 0; i < MAX_RES; i++) begin
			idx     = bytes_n - cnt_t'(np) + cnt_t'(i);
			keep[i] = (2'(i) < np) && (no_cut || (idx < expected));
		end
		if (!eos_s1) begin
			// Oldest held byte pushed out by a new one
			if (has_new && (hcnt_q == 2'(HOLD_DEPTH))) begin
				batch.num     = 2'd1;
				batch.item[0] = '{out_byte: held_q[0], byte_valid: 1'b1,
					decode_error: 1'b0, last_result: 1'b0};
			end
		end else if (err_n) begin
			batch.num     = 2'd1;
			batch.item[0] = '{out_byte: 8'h00, byte_valid: 1'b0,
				decode_error: 1'b1, last_result: 1'b1};
		end else begin
			// Release held and new bytes that fall inside the expected length
			for (int i = 0; i < MAX_RES; i++) begin
				if (keep[i]) begin
					batch.item[n] = '{out_byte: pend[i], byte_valid: 1'b1,
						decode_error: 1'b0, last_result: 1'b0};
					n = n + 2'd1;
				end
			end
			if (n == 2'd0) begin
				batch.num     = 2'd1;
				batch.item[0] = '{out_byte: 8'h00, byte_valid: 1'b0,
					decode_error: 1'b0, last_result: 1'b1};
			end else begin
				batch.num                     = n;
				batch.item[n - 2'd1].last_result = 1'b1;
			end
		end
		if (!adv) begin
			batch.num = 2'd0;
		end
	end

	// Decode state update; end of string returns everything to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			off_q    <= OFF_RESET;
			hcnt_q   <= '0;
			bytes_q  <= '0;
			chars_q  <= '0;
			groups_q <= '0;
			pad_q    <= '0;
			err_q    <= 1'b0;
		end else if (adv) begin
			if (eos_s1) begin
				acc_q    <= '0;
				off_q    <= OFF_RESET;
				hcnt_q   <= '0;
				bytes_q  <= '0;
				chars_q  <= '0;
				groups_q <= '0;
				pad_q    <= '0;
				err_q    <= 1'b0;
			end else begin
				acc_q    <= acc_n;
				off_q    <= off_n;
				bytes_q  <= bytes_n;
				chars_q  <= chars_n;
				groups_q <= groups_n;
				pad_q    <= pad_n;
				err_q    <= err_n;
				if (err_n) begin
					hcnt_q <= '0;
				end else if (has_new && (hcnt_q != 2'(HOLD_DEPTH))) begin
					hcnt_q <= hcnt_q + 2'd1;
				end
			end
		end
	end

	// Hold-back bytes
	always_ff @(posedge clk) begin
		if (adv && !eos_s1 && has_new) begin
			if (hcnt_q == 2'(HOLD_DEPTH)) begin
				held_q[0] <= held_q[1];
				held_q[1] <= nb;
			end else begin
				held_q[hcnt_q[0]] <= nb;
			end
		end
	end

`ifndef SYNTHESIS
	a_off_range: assert property (@(posedge clk) disable iff (!arst_n)
		(off_q == -4'sd8) || (off_q == -4'sd6) || (off_q == -4'sd4) || (off_q == -4'sd2))
		else $error("bit offset out of range");
	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && eos_s1 |-> (batch.num != 2'd0))
		else $error("end of string without a result");
	a_mid_single: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !eos_s1 |-> (batch.num <= 2'd1))
		else $error("more than one result before end of string");
	a_err_clears_hold: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !eos_s1 && err_n |=> (hcnt_q == 2'd0))
		else $error("held bytes kept after an error");
`endif

endmodule

// ===== rtl/core/b64_outq.sv =====
// Result queue: takes up to three results a cycle, sends one a beat.
module b64_outq import b64_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  batch_t      batch,
	output logic        room,
	b64_res_if.source   res_ch
);

	res_t       q_q [QDEPTH];
	logic [1:0] head_q;
	logic [1:0] tail_q;
	logic [2:0] cnt_q;
	logic       pop;

	// Room for a full end-of-string batch
	assign room = (cnt_q <= 3'(QDEPTH - MAX_RES));
	assign pop  = (cnt_q != 3'd0) && res_ch.ready;

	assign res_ch.valid        = (cnt_q != 3'd0);
	assign res_ch.out_byte     = q_q[head_q].out_byte;
	assign res_ch.byte_valid   = q_q[head_q].byte_valid;
	assign res_ch.decode_error = q_q[head_q].decode_error;
	assign res_ch.last_result  = q_q[head_q].last_result;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			tail_q <= tail_q + batch.num;
			if (pop) begin
				head_q <= head_q + 2'd1;
			end
			cnt_q <= cnt_q + 3'(batch.num) - 3'(pop);
		end
	end

	// Entry writes
	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_RES; j++) begin
			if (2'(j) < batch.num) begin
				q_q[tail_q + 2'(j)] <= batch.item[j];
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(QDEPTH))
		else $error("result queue overflow");
	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(batch.num != 2'd0) |-> room)
		else $error("results pushed without room");
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid && res_ch.decode_error |-> res_ch.last_result && !res_ch.byte_valid)
		else $error("error flag on a result that is not the final one");
`endif

endmodule

// ===== rtl/core/base64_stream_decoder.sv =====
// Top level of the streaming base64 decoder.
//
//  channel   dir  payload                                            beat per
//  char_ch   in   char_in[7:0], end_of_string                        character
//  res_ch    out  out_byte[7:0], byte_valid, decode_error, last_result  result
//
// One character enters per cycle while the queue has room; it is decoded
// in the input register and its results go to a four-entry queue.
// A character mid-string gives at most one result; the end-of-string
// character gives up to three, which leave one per beat.
// The input stalls only while the queue holds more than one result.
// arst_n clears the decode state and the queue; no clearing pass is needed.
module base64_stream_decoder import b64_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	b64_char_if.sink   char_ch,
	b64_res_if.source  res_ch
);

	batch_t batch;
	logic   room;

	b64_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_ch (char_ch),
		.room    (room),
		.batch   (batch)
	);

	b64_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.batch  (batch),
		.room   (room),
		.res_ch (res_ch)
	);

endmodule
